// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, disabled while reset is low.
`define IBP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the standard clock and reset names.
`define IBP_ASSERT_STD(label, prop, msg) \
    `IBP_ASSERT(label, i_clk, i_rst_n, prop, msg)

`endif

// ----- design/ibp_pkg.sv -----
// ---------------------------------------------------------------------------
// ibp_pkg
// Widths, limits and helpers for the index bit packer.
// ---------------------------------------------------------------------------
package ibp_pkg;

    localparam int INDEX_W          = 32;  // input index port width
    localparam int IDX_BITS_W       = 5;   // width config register
    localparam int MAX_INDEX_BITS   = 25;
    localparam int MIN_INDEX_BITS   = 8;
    localparam int RESET_INDEX_BITS = 21;
    localparam int BYTE_W           = 8;
    localparam int ACC_W            = 32;  // up to 7 waiting bits + 25 new bits
    localparam int PEND_W           = 3;   // waiting bit count, 0..7
    localparam int PEND_ACC_W       = 7;   // waiting bits themselves
    localparam int CNT_W            = 3;   // bytes per word, 1..4
    localparam int HAVE_W           = 6;   // total bits, up to 32

    // Clamp the programmed width into the supported range.
    function automatic logic [IDX_BITS_W-1:0] eff_width(input logic [IDX_BITS_W-1:0] raw);
        logic [IDX_BITS_W-1:0] w;
        w = raw;
        if (raw < IDX_BITS_W'(MIN_INDEX_BITS)) begin
            w = IDX_BITS_W'(MIN_INDEX_BITS);
        end else if (raw > IDX_BITS_W'(MAX_INDEX_BITS)) begin
            w = IDX_BITS_W'(MAX_INDEX_BITS);
        end
        return w;
    endfunction

endpackage

// ----- design/index_bit_packer_unit.sv -----
// ---------------------------------------------------------------------------
// index_bit_packer_unit
// Appends each index (cut to the programmed width) to a bit accumulator and
// streams out every complete byte, most significant first.
// ---------------------------------------------------------------------------
// Path: a taken word is loaded into r_buf, then its bytes move to the output register.
// Throughput: one output byte per cycle while i_out_stall is low; a word gives n
//   bytes (1..4) through the single byte-wide output register. The next
//   word is taken in the cycle its predecessor's final byte leaves the buffer.
// Reset (synchronous, active low): width 21, accumulator empty, no output.
// ---------------------------------------------------------------------------
module index_bit_packer_unit
    import ibp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_wr_en,
    input  logic [IDX_BITS_W-1:0] i_cfg_wr_data,
    // input words
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [INDEX_W-1:0]    i_index_value,
    input  logic                  i_last_index,
    // output bytes
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [BYTE_W-1:0]     o_out_byte,
    output logic                  o_last_of_run,
    output logic                  o_end_of_stream
);

    logic [IDX_BITS_W-1:0] r_index_bits;
    logic [PEND_W-1:0]     r_pend_cnt;
    logic [PEND_ACC_W-1:0] r_pend_acc;
    logic [ACC_W-1:0]      r_buf;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_buf_last;
    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_out_byte;
    logic                  r_out_lor;
    logic                  r_out_eos;

    logic [IDX_BITS_W-1:0]     w;
    logic [MAX_INDEX_BITS-1:0] idx;
    logic [ACC_W-1:0]          acc;
    logic [HAVE_W-1:0]         have;
    logic [ACC_W-1:0]          n_buf;
    logic [PEND_ACC_W-1:0]     n_pend_acc;
    logic                      out_load;
    logic                      in_ready;
    logic                      in_take;

    always_comb begin
        w    = eff_width(r_index_bits);
        idx  = i_index_value[MAX_INDEX_BITS-1:0] & ~({MAX_INDEX_BITS{1'b1}} << w);
        acc  = ({{(ACC_W-PEND_ACC_W){1'b0}}, r_pend_acc} << w)
             | {{(ACC_W-MAX_INDEX_BITS){1'b0}}, idx};
        have = {{(HAVE_W-PEND_W){1'b0}}, r_pend_cnt} + {{(HAVE_W-IDX_BITS_W){1'b0}}, w};
        // left-align so the oldest bit sits at the MSB
        n_buf      = acc << (HAVE_W'(ACC_W) - have);
        n_pend_acc = acc[PEND_ACC_W-1:0] & ~({PEND_ACC_W{1'b1}} << have[PEND_W-1:0]);
    end

    assign out_load = (r_cnt != '0) && (!r_out_valid || !i_out_stall);
    assign in_ready = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && out_load);
    assign in_take  = i_in_valid && in_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits <= IDX_BITS_W'(RESET_INDEX_BITS);
            r_pend_cnt   <= '0;
            r_pend_acc   <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_index_bits <= i_cfg_wr_data;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (in_take) begin
                r_cnt <= have[HAVE_W-1:PEND_W];
                if (i_last_index) begin
                    r_pend_cnt <= '0;
                    r_pend_acc <= '0;
                end else begin
                    r_pend_cnt <= have[PEND_W-1:0];
                    r_pend_acc <= n_pend_acc;
                end
            end else if (out_load) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= r_buf[ACC_W-1 -: BYTE_W];
            r_out_lor  <= (r_cnt == CNT_W'(1));
            r_out_eos  <= (r_cnt == CNT_W'(1)) && r_buf_last;
        end
        if (in_take) begin
            r_buf      <= n_buf;
            r_buf_last <= i_last_index;
        end else if (out_load) begin
            r_buf <= r_buf << BYTE_W;
        end
    end

    assign o_in_stall      = !in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_last_of_run   = r_out_lor;
    assign o_end_of_stream = r_out_eos;

endmodule

// ----- design/ibp_checker.sv -----
// ---------------------------------------------------------------------------
// ibp_checker
// Port-level checks for the index bit packer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ibp_checker
    import ibp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [BYTE_W-1:0]     o_out_byte,
    input logic                  o_last_of_run,
    input logic                  o_end_of_stream
);

    // held byte keeps its payload
    `IBP_ASSERT_STD(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte) && $stable(o_last_of_run) && $stable(o_end_of_stream), "stalled output byte changed")

    // stream end marker only on the final byte of a word
    `IBP_ASSERT_STD(a_eos_is_lor, o_out_valid && o_end_of_stream |-> o_last_of_run, "end of stream without last of run")

    // bytes of one word come without gaps
    `IBP_ASSERT_STD(a_run_no_gap, o_out_valid && !i_out_stall && !o_last_of_run |=> o_out_valid, "gap inside a word's bytes")

    // a taken word is followed by a valid output byte
    `IBP_ASSERT_STD(a_take_to_out, i_in_valid && !o_in_stall |-> ##2 o_out_valid, "taken word produced no byte")

endmodule

bind index_bit_packer_unit ibp_checker u_ibp_checker (.*);

// ----- test/tb_index_bit_packer_unit.sv -----
// ---------------------------------------------------------------------------
// tb_index_bit_packer_unit
// Self-checking bench for the index bit packer. A directed table and then
// random solution sequences are fed in, over several field widths, some of
// them out of range. Each accepted word is packed by a local model into the
// bytes it should produce (or a table row gives them by hand), and every
// output byte is checked against them in order. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_index_bit_packer_unit;
    import ibp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [IDX_BITS_W-1:0] i_cfg_wr_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [INDEX_W-1:0]    i_index_value;
    logic                  i_last_index;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_last_of_run;
    logic                  o_end_of_stream;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last_of_run;
        logic              end_of_stream;
    } packed_byte_t;

    // bytes written out by hand for a row, first byte in the top bits
    typedef struct {
        int          n;
        logic [31:0] bytes;
    } known_bytes_t;

    typedef struct {
        bit                    cfg_wr;
        logic [IDX_BITS_W-1:0] width;
        logic [INDEX_W-1:0]    index;
        logic                  last;
        int                    n;
        logic [31:0]           bytes;
    } dir_row_t;

    packed_byte_t   packed_q[$];
    known_bytes_t   known_q[$];
    dir_row_t       dir_rows[$];

    // packer model state
    logic [IDX_BITS_W-1:0] width_reg = IDX_BITS_W'(RESET_INDEX_BITS);
    logic [31:0]           pend_bits_q = '0;
    logic [PEND_W-1:0]     pend_cnt_q = '0;

    int err_cnt = 0;
    int tx_max  = 7;
    int rx_max  = 7;

    index_bit_packer_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_index_value   (i_index_value),
        .i_last_index    (i_last_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_stream (o_end_of_stream)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (err_cnt < 50) $display("ERROR @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic add_row(input bit cfg_wr, input logic [IDX_BITS_W-1:0] width,
                           input logic [INDEX_W-1:0] index, input logic last,
                           input int n, input logic [31:0] bytes);
        dir_row_t r;
        r.cfg_wr = cfg_wr;
        r.width  = width;
        r.index  = index;
        r.last   = last;
        r.n      = n;
        r.bytes  = bytes;
        dir_rows.push_back(r);
    endtask

    // Present one word and hold it until taken.
    task automatic send_index(input logic [INDEX_W-1:0] index, input logic last,
                              input int n, input logic [31:0] bytes);
        int gap;
        known_bytes_t k;
        gap = $urandom_range(0, tx_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        k.n     = n;
        k.bytes = bytes;
        known_q.push_back(k);
        i_in_valid    <= 1'b1;
        i_index_value <= index;
        i_last_index  <= last;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
    endtask

    // Width changes only with the block drained.
    task automatic write_width(input logic [IDX_BITS_W-1:0] width);
        i_in_valid <= 1'b0;
        while (packed_q.size() != 0 || known_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= width;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Receiver: after each byte, stall for a random number of cycles.
    initial begin : byte_sink
        int hold;
        hold = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) hold = $urandom_range(0, rx_max);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                hold--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Checks output bytes, then packs each accepted word into expected bytes.
    always @(posedge i_clk) begin : monitor
        logic [63:0]  acc;
        logic [63:0]  field_mask;
        int           w;
        int           have;
        int           n;
        logic [7:0]   bytes [4];
        known_bytes_t k;
        packed_byte_t e;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (packed_q.size() == 0) begin
                    report_mismatch($sformatf("byte %02h with nothing expected", o_out_byte));
                end else begin
                    e = packed_q.pop_front();
                    if (o_out_byte !== e.data)
                        report_mismatch($sformatf("byte %02h, expected %02h",
                                                  o_out_byte, e.data));
                    if (o_last_of_run !== e.last_of_run)
                        report_mismatch($sformatf("last_of_run %b, expected %b (byte %02h)",
                                                  o_last_of_run, e.last_of_run, e.data));
                    if (o_end_of_stream !== e.end_of_stream)
                        report_mismatch($sformatf("end_of_stream %b, expected %b (byte %02h)",
                                                  o_end_of_stream, e.end_of_stream, e.data));
                end
            end
            if (i_cfg_wr_en) width_reg = i_cfg_wr_data;
            if (i_in_valid && !o_in_stall) begin
                w = int'(width_reg);
                if (w < MIN_INDEX_BITS) w = MIN_INDEX_BITS;
                if (w > MAX_INDEX_BITS) w = MAX_INDEX_BITS;
                field_mask = (64'd1 << w) - 64'd1;
                acc  = ({32'd0, pend_bits_q} << w) | ({32'd0, i_index_value} & field_mask);
                have = int'(pend_cnt_q) + w;
                n    = 0;
                while (have >= 8) begin
                    have -= 8;
                    bytes[n] = acc[have +: 8];
                    n++;
                end
                if (i_last_index) begin
                    pend_bits_q = '0;
                    pend_cnt_q  = '0;
                end else begin
                    pend_cnt_q  = PEND_W'(have);
                    pend_bits_q = acc[31:0] & ((32'd1 << have) - 32'd1);
                end
                k = known_q.pop_front();
                if (k.n > 0) begin
                    n = k.n;
                    for (int i = 0; i < n; i++) bytes[i] = k.bytes[31 - 8 * i -: 8];
                end
                for (int i = 0; i < n; i++) begin
                    e.data          = bytes[i];
                    e.last_of_run   = (i == n - 1);
                    e.end_of_stream = (i == n - 1) && i_last_index;
                    packed_q.push_back(e);
                end
            end
        end
    end

    initial begin : stimulus
        dir_row_t            r;
        int                  cnt;
        int                  len;
        logic [INDEX_W-1:0]  v;
        logic [IDX_BITS_W-1:0] phase_width;

        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        i_in_valid    <= 1'b0;
        i_index_value <= '0;
        i_last_index  <= 1'b0;

        // reset width 21: a lone last word gives two bytes, five bits dropped
        add_row(0, 0, 32'h001F_FFFF, 1, 2, 32'hFFFF_0000);
        add_row(0, 0, 32'h0000_0000, 1, 2, 32'h0000_0000);
        add_row(0, 0, 32'hFFE0_0000, 1, 2, 32'h0000_0000);
        add_row(0, 0, 32'hFFFF_FFFF, 1, 2, 32'hFFFF_0000);
        add_row(0, 0, 32'h0015_5555, 0, 0, 0);
        add_row(0, 0, 32'h000A_AAAA, 0, 0, 0);
        add_row(0, 0, 32'h0010_0001, 0, 0, 0);
        add_row(0, 0, 32'h001F_FFFF, 0, 0, 0);
        add_row(0, 0, 32'h0000_0000, 0, 0, 0);
        add_row(0, 0, 32'h0001_2345, 0, 0, 0);
        add_row(0, 0, 32'hFFFA_BCDE, 0, 0, 0);
        add_row(0, 0, 32'h0000_0001, 1, 0, 0);
        add_row(1, 5'd8,  32'h0000_00AB, 0, 1, 32'hAB00_0000);
        add_row(0, 0,     32'hFFFF_FF00, 1, 1, 32'h0000_0000);
        // widths below 8 and above 25 clamp
        add_row(1, 5'd0,  32'h0000_1234, 1, 1, 32'h3400_0000);
        add_row(1, 5'd31, 32'h01FF_FFFF, 1, 3, 32'hFFFF_FF00);
        add_row(0, 0,     32'h0000_0000, 0, 0, 0);
        add_row(0, 0,     32'h0155_5555, 1, 0, 0);
        add_row(1, 5'd25, 32'hFFFF_FFFF, 1, 3, 32'hFFFF_FF00);
        add_row(0, 0,     32'h00AA_AAAA, 0, 0, 0);
        add_row(0, 0,     32'h0100_0000, 1, 0, 0);
        add_row(1, 5'd7,  32'h0000_00FF, 0, 1, 32'hFF00_0000);
        add_row(1, 5'd26, 32'h03FF_FFFF, 1, 3, 32'hFFFF_FF00);
        add_row(1, 5'd9,  32'h0000_01FF, 0, 0, 0);
        add_row(0, 0,     32'h8000_0100, 0, 0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.cfg_wr) write_width(r.width);
            send_index(r.index, r.last, r.n, r.bytes);
        end

        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       phase_width = 5'd8;
                1:       phase_width = 5'd25;
                2:       phase_width = 5'd0;
                3:       phase_width = 5'd31;
                4:       phase_width = 5'd21;
                default: phase_width = IDX_BITS_W'($urandom_range(0, 31));
            endcase
            case (p)
                4:       begin tx_max = 0; rx_max = 0; end
                6:       begin tx_max = 0; rx_max = 7; end
                7:       begin tx_max = 7; rx_max = 0; end
                default: begin tx_max = 7; rx_max = 7; end
            endcase
            write_width(phase_width);
            cnt = 0;
            while (cnt < 35) begin
                if ($urandom_range(0, 9) == 0) begin
                    // stray word with a random end flag
                    send_index($urandom, 1'($urandom_range(0, 1)), 0, 0);
                    cnt++;
                end else begin
                    len = $urandom_range(1, 10);
                    for (int k = 0; k < len; k++) begin
                        case ($urandom_range(0, 7))
                            0:       v = '1;
                            1:       v = '0;
                            default: v = $urandom;
                        endcase
                        send_index(v, k == len - 1, 0, 0);
                        cnt++;
                    end
                end
            end
        end

        i_in_valid <= 1'b0;
        while (packed_q.size() != 0 || known_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (packed_q.size() != 0)
            report_mismatch($sformatf("%0d bytes never arrived", packed_q.size()));
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
